[rtl/jcmd_pkg.sv]
// Package for the joystick calibrate/map/deadband block.
// Holds the sequencer state type and the mapping constants; no dependencies.
package jcmd_pkg;

    // Default raw sample width
    localparam int SAMPLE_BITS_DEF = 12;

    // Output ranges and mapping gains
    localparam int POS_MAX    = 180;
    localparam int POS_CENTER = 90;
    localparam int POS_DB_LO  = 80;
    localparam int POS_DB_HI  = 100;
    localparam int SPD_HI     = 100;
    localparam int SPD_LO     = -100;
    localparam int SPD_DB_LO  = -10;
    localparam int SPD_DB_HI  = 11;
    localparam int SPD_GAIN   = 200;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_POST,
        S_OUT
    } t_state;

endpackage

[rtl/joystick_calibrate_map_deadband_core.sv]
// Joystick calibration, linear map and deadband: one sequencer around a shared divider.
// Depends on jcmd_pkg for the state type and constants.
// Calibration items give no result. A mapped item runs X, then Y, through the
// restoring divider (one quotient bit per cycle), each axis in S_SETUP, S_DIV and S_POST;
// a flat axis skips S_DIV. The result is registered in S_OUT and no new item is taken until S_IDLE;
// a stalled output holds S_OUT. Sync active-low reset: calibrate, min all ones, max 0.
module joystick_calibrate_map_deadband_core #(
    parameter int SAMPLE_BITS = jcmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_x_raw,
    input  logic [SAMPLE_BITS-1:0] i_y_raw,
    input  logic                   i_button_pressed,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_position,
    output logic signed [7:0]      o_speed,
    output logic                   o_turbo
);
    import jcmd_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int DW = SAMPLE_BITS + 8;
    localparam int VW = DW + 2;
    localparam int CW = $clog2(DW);

    localparam logic signed [VW-1:0] C_POS_MAX = VW'(POS_MAX);
    localparam logic signed [VW-1:0] C_POS_DBL = VW'(POS_DB_LO);
    localparam logic signed [VW-1:0] C_POS_DBH = VW'(POS_DB_HI);
    localparam logic signed [VW-1:0] C_SPD_HI  = VW'(SPD_HI);
    localparam logic signed [VW-1:0] C_SPD_LO  = VW'(SPD_LO);
    localparam logic signed [VW-1:0] C_SPD_DBL = VW'(SPD_DB_LO);
    localparam logic signed [VW-1:0] C_SPD_DBH = VW'(SPD_DB_HI);

    t_state r_state, n_state;

    logic          r_calib;
    logic [SW-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [SW-1:0] r_x, r_y;
    logic          r_btn;
    logic          r_axis;
    logic          r_neg;
    logic          r_flat;
    logic [SW-1:0] r_div;
    logic [SW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_pos;
    logic [7:0]    r_out_pos;
    logic [7:0]    r_out_spd;
    logic          r_out_turbo;
    logic          r_out_valid;

    logic                 in_acc;
    logic                 out_free;
    logic [SW-1:0]        sel_v, sel_min, sel_max;
    logic signed [SW:0]   diff, span;
    logic [SW:0]          diff_abs, span_abs;
    logic [DW-1:0]        num_mag;
    logic                 num_neg;
    logic [SW:0]          trial;
    logic                 q_bit;
    logic signed [VW-1:0] q_s, val;
    logic [7:0]           pos_res, spd_res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Operand selection and numerator for the current axis
    always_comb begin
        sel_v    = r_axis ? r_y     : r_x;
        sel_min  = r_axis ? r_y_min : r_x_min;
        sel_max  = r_axis ? r_y_max : r_x_max;
        diff     = $signed({1'b0, sel_v})   - $signed({1'b0, sel_min});
        span     = $signed({1'b0, sel_max}) - $signed({1'b0, sel_min});
        diff_abs = diff[SW] ? (SW+1)'(-diff) : diff;
        span_abs = span[SW] ? (SW+1)'(-span) : span;
        num_mag  = DW'(diff_abs[SW-1:0]) * (r_axis ? DW'(SPD_GAIN) : DW'(POS_MAX));
        num_neg  = (r_axis ? !diff[SW] : diff[SW]) ^ span[SW];
    end

    // One restoring division step
    always_comb begin
        trial = {r_rem, r_quo[DW-1]} - {1'b0, r_div};
        q_bit = !trial[SW];
    end

    // Sign, offset, saturation and deadband of the finished quotient
    always_comb begin
        q_s = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
        val = q_s + (r_axis ? C_SPD_HI : '0);

        if (r_flat) begin
            pos_res = 8'(POS_CENTER);
        end else if (val < 0) begin
            pos_res = '0;
        end else if (val > C_POS_MAX) begin
            pos_res = 8'(POS_MAX);
        end else if (val > C_POS_DBL && val < C_POS_DBH) begin
            pos_res = 8'(POS_CENTER);
        end else begin
            pos_res = val[7:0];
        end

        if (r_flat) begin
            spd_res = '0;
        end else if (val < C_SPD_LO) begin
            spd_res = 8'(SPD_LO);
        end else if (val > C_SPD_HI) begin
            spd_res = 8'(SPD_HI);
        end else if (val > C_SPD_DBL && val < C_SPD_DBH) begin
            spd_res = '0;
        end else begin
            spd_res = val[7:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && !r_calib) n_state = S_SETUP;
            S_SETUP: n_state = (span == 0) ? S_POST : S_DIV;
            S_DIV:   if (r_cnt == '0) n_state = S_POST;
            S_POST:  n_state = r_axis ? S_OUT : S_SETUP;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Calibration bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= 1'b1;
            r_x_min <= '1;
            r_x_max <= '0;
            r_y_min <= '1;
            r_y_max <= '0;
        end else if (in_acc && r_calib) begin
            if (i_button_pressed) begin
                r_calib <= 1'b0;
            end else begin
                if (i_x_raw < r_x_min) r_x_min <= i_x_raw;
                if (i_x_raw > r_x_max) r_x_max <= i_x_raw;
                if (i_y_raw < r_y_min) r_y_min <= i_y_raw;
                if (i_y_raw > r_y_max) r_y_max <= i_y_raw;
            end
        end
    end

    // Datapath: capture item, load divider, iterate, keep X result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_x    <= i_x_raw;
                    r_y    <= i_y_raw;
                    r_btn  <= i_button_pressed;
                    r_axis <= 1'b0;
                end
            end
            S_SETUP: begin
                r_div  <= span_abs[SW-1:0];
                r_rem  <= '0;
                r_quo  <= num_mag;
                r_neg  <= num_neg;
                r_flat <= (span == 0);
                r_cnt  <= CW'(DW - 1);
            end
            S_DIV: begin
                r_rem <= q_bit ? trial[SW-1:0] : {r_rem[SW-2:0], r_quo[DW-1]};
                r_quo <= {r_quo[DW-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
            end
            S_POST: begin
                if (!r_axis) begin
                    r_pos  <= pos_res;
                    r_axis <= 1'b1;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // Output register; the Y quotient is held through S_OUT, so speed is taken here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
            r_out_pos   <= r_pos;
            r_out_spd   <= spd_res;
            r_out_turbo <= r_btn;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_speed     = $signed(r_out_spd);
    assign o_turbo     = r_out_turbo;

    // Divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div != '0)
        else $error("divider running with zero divisor");

    // Calibration items never produce a result
    a_calib_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_calib) |=> !$rose(o_out_valid))
        else $error("result produced during calibration");

    // Calibration, once left, is never re-entered
    a_calib_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_calib |=> !r_calib)
        else $error("calibration re-entered");

    // Results stay within their saturated ranges
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_position <= 8'(POS_MAX) && o_speed >= -8'sd100
                         && o_speed <= 8'sd100))
        else $error("result out of range");

endmodule
